// ===== rtl/core/rmgc_pkg.sv =====
// Package for the region map greedy coloring core: payload structs and constants.
// No dependencies.
`timescale 1ns / 1ps
package rmgc_pkg;
  localparam int unsigned MAX_SIDE    = 256;
  localparam int unsigned MAX_REGIONS = 32;
  localparam int unsigned NUM_COLORS  = 25;

  localparam int unsigned IdW    = 5;
  localparam int unsigned ColorW = 5;
  localparam int unsigned SideW  = 9;
  localparam int unsigned CountW = 6;
  localparam int unsigned CfgW   = 9;
  localparam int unsigned ColW   = $clog2(MAX_SIDE);
  localparam int unsigned RegW   = $clog2(MAX_REGIONS);
  localparam int unsigned UseW   = $clog2(MAX_REGIONS + 1);

  // Configuration register indexes
  localparam logic CFG_GRID_SIDE    = 1'b0;
  localparam logic CFG_REGION_COUNT = 1'b1;

  typedef struct packed {
    logic [IdW-1:0] region_id;
    logic           assigned;
    logic           last_cell;
  } cell_t;

  typedef struct packed {
    logic [IdW-1:0]    region_index;
    logic [ColorW-1:0] color_index;
    logic              conflict;
    logic              last_region;
  } result_t;
endpackage

// ===== rtl/core/rmgc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rmgc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/region_map_greedy_coloring_core.sv =====
// Top level of the region map greedy coloring core.
// Depends on rmgc_pkg and rmgc_ram.
//
//  channel | signals                     | taken when
//  --------+-----------------------------+-------------------------
//  cell    | start, busy, label          | start && !busy
//  result  | result_valid, result        | result_valid (no stall)
//  config  | cfg_we, cfg_index, cfg_data | cfg_we
//
// A cell transaction passes through S_ABOVE alone when it makes no link, and
// through one S_RD/S_WR pair more for each adjacency row it updates: its own
// row and the row of each linked neighbor. After the final cell, each region
// passes through S_CRD (adjacency row read), S_BLK (blocked mask), S_SCAN (each
// color in turn) and S_PICK; the S_CRD after the last region clears map state.
// Reset clears positions, usage counts and adjacency valid bits at once.
// Results leave the cycle after they are picked; the receiver cannot stall.
`timescale 1ns / 1ps
module region_map_greedy_coloring_core
  import rmgc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  cell_t           label,
  output logic            result_valid,
  output result_t         result,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [CfgW-1:0] cfg_data
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ABOVE = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_WR    = 8'b0000_1000,
    S_CRD   = 8'b0001_0000,
    S_BLK   = 8'b0010_0000,
    S_SCAN  = 8'b0100_0000,
    S_PICK  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [SideW-1:0]  grid_side;
  logic [CountW-1:0] region_count;
  logic [SideW-1:0]  side_eff;
  logic [RegW:0]     count_eff;
  logic [ColW:0]     column_position;
  logic [7:0]        row_position;
  logic [IdW:0]      left_cell;
  logic [IdW:0]      here;
  logic [IdW:0]      cell_in;
  logic              last_hold;
  logic              accept;
  logic              wrap;
  logic [ColW-1:0]   col;
  logic              left_ok_now, up_ok_now;

  // Pending adjacency row updates: bit 0 own row, bit 1 left row, bit 2 upper row.
  logic                   link_left_ok, link_up_ok;
  logic [RegW-1:0]        left_id, above_id;
  logic [2:0]             upd_pend, upd_first, upd_rest;
  logic [RegW-1:0]        upd_addr;
  logic [MAX_REGIONS-1:0] upd_mask;

  logic [MAX_REGIONS-1:0] adj_valid;
  logic                   adj_we;
  logic [RegW-1:0]        adj_raddr;
  logic [MAX_REGIONS-1:0] adj_wdata, adj_rdata, nbr;

  // Row buffer: bit IdW marks an assigned cell.
  logic [IdW:0]      rb_rdata;

  logic [ColorW-1:0]     colors [MAX_REGIONS];
  logic [UseW-1:0]       usage  [NUM_COLORS];
  logic [RegW:0]         region;
  logic [ColorW-1:0]     scan_c;
  logic [NUM_COLORS-1:0] blocked, blocked_now;
  logic                  have_free;
  logic [ColorW-1:0]     best_free, best_any, pick;
  logic                  free_take, any_take;

  // Read the row above and write the new cell in the accept cycle; the read
  // returns the old entry.
  rmgc_ram #(.WIDTH(IdW + 1), .DEPTH(MAX_SIDE)) u_row_buffer (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (cell_in),
    .raddr (col),
    .rdata (rb_rdata)
  );

  rmgc_ram #(.WIDTH(MAX_REGIONS), .DEPTH(MAX_REGIONS)) u_adjacency (
    .clk   (clk),
    .we    (adj_we),
    .waddr (upd_addr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // Effective side and count after clamping.
  always_comb begin
    side_eff = grid_side;
    if (grid_side < SideW'(2)) side_eff = SideW'(2);
    if (grid_side > SideW'(MAX_SIDE)) side_eff = SideW'(MAX_SIDE);
    count_eff = (region_count > CountW'(MAX_REGIONS)) ? (RegW+1)'(MAX_REGIONS)
                                                       : (RegW+1)'(region_count);
  end

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  // Wrap at once when the column has run past the side.
  assign wrap   = (column_position >= side_eff);
  assign col    = wrap ? '0 : column_position[ColW-1:0];

  assign cell_in = label.assigned ? {1'b1, label.region_id} : '0;

  // Link only different assigned labels; no left link in column zero, no
  // upper link in row zero.
  assign left_ok_now = cell_in[IdW] && (col != '0) && left_cell[IdW]
                       && (left_cell[IdW-1:0] != cell_in[IdW-1:0]);
  assign up_ok_now   = here[IdW] && (row_position != 8'd0) && rb_rdata[IdW]
                       && (rb_rdata[IdW-1:0] != here[IdW-1:0]);

  // Adjacency read-modify-write, one row per read/write pair; a row never
  // written since the last clear reads as zero.
  always_comb begin
    upd_first = upd_pend[0] ? 3'b001 : (upd_pend[1] ? 3'b010 : 3'b100);
    upd_rest  = upd_pend & ~upd_first;
    if (upd_pend[0]) begin
      upd_addr = here[IdW-1:0];
      upd_mask = (link_left_ok ? (MAX_REGIONS'(1) << left_id) : '0)
               | (link_up_ok ? (MAX_REGIONS'(1) << above_id) : '0);
    end else if (upd_pend[1]) begin
      upd_addr = left_id;
      upd_mask = MAX_REGIONS'(1) << here[IdW-1:0];
    end else begin
      upd_addr = above_id;
      upd_mask = MAX_REGIONS'(1) << here[IdW-1:0];
    end
    adj_we    = (state == S_WR);
    adj_wdata = (adj_valid[upd_addr] ? adj_rdata : '0) | upd_mask;
    adj_raddr = (state == S_RD) ? upd_addr : region[RegW-1:0];
  end

  // Color choice: block colors of lower neighbors, then scan one color a cycle.
  always_comb begin
    nbr = adj_valid[region[RegW-1:0]] ? adj_rdata : '0;
    blocked_now = '0;
    for (int j = 0; j < MAX_REGIONS; j++) begin
      if (nbr[j] && ((RegW+1)'(j) < region)) blocked_now[colors[j]] = 1'b1;
    end
    free_take = !blocked[scan_c] && (!have_free || (usage[scan_c] < usage[best_free]));
    any_take  = usage[scan_c] < usage[best_any];
    pick      = have_free ? best_free : best_any;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_ABOVE;
      S_ABOVE: begin
        if (link_left_ok || up_ok_now) state_next = S_RD;
        else if (last_hold) state_next = S_CRD;
        else state_next = S_IDLE;
      end
      S_RD:    state_next = S_WR;
      S_WR:    begin
        if (upd_rest != 3'b000) state_next = S_RD;
        else if (last_hold) state_next = S_CRD;
        else state_next = S_IDLE;
      end
      S_CRD:   state_next = (region < count_eff) ? S_BLK : S_IDLE;
      S_BLK:   state_next = S_SCAN;
      S_SCAN:  if (scan_c == ColorW'(NUM_COLORS - 1)) state_next = S_PICK;
      S_PICK:  state_next = S_CRD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      grid_side       <= SideW'(16);
      region_count    <= CountW'(1);
      column_position <= '0;
      row_position    <= '0;
      left_cell       <= '0;
      here            <= '0;
      last_hold       <= 1'b0;
      link_left_ok    <= 1'b0;
      link_up_ok      <= 1'b0;
      left_id         <= '0;
      above_id        <= '0;
      upd_pend        <= '0;
      adj_valid       <= '0;
      region          <= '0;
      scan_c          <= '0;
      blocked         <= '0;
      have_free       <= 1'b0;
      best_free       <= '0;
      best_any        <= '0;
      result_valid    <= 1'b0;
      result          <= '0;
      for (int c = 0; c < NUM_COLORS; c++) usage[c] <= '0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_SIDE:    grid_side    <= cfg_data;
          CFG_REGION_COUNT: region_count <= cfg_data[CountW-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (accept) begin
          // Take the cell and advance the position; the row counter saturates.
          here            <= cell_in;
          last_hold       <= label.last_cell;
          link_left_ok    <= left_ok_now;
          left_id         <= left_cell[IdW-1:0];
          left_cell       <= cell_in;
          column_position <= {1'b0, col} + (ColW+1)'(1);
          if (wrap && row_position != 8'd255) row_position <= row_position + 8'd1;
        end
        S_ABOVE: begin
          link_up_ok <= up_ok_now;
          above_id   <= rb_rdata[IdW-1:0];
          upd_pend   <= {up_ok_now, link_left_ok, link_left_ok || up_ok_now};
        end
        S_WR: begin
          adj_valid[upd_addr] <= 1'b1;
          upd_pend            <= upd_rest;
        end
        S_CRD: if (region >= count_eff) begin
          // Clear map state for the next map.
          adj_valid       <= '0;
          column_position <= '0;
          row_position    <= '0;
          left_cell       <= '0;
          region          <= '0;
          for (int c = 0; c < NUM_COLORS; c++) usage[c] <= '0;
        end
        S_BLK: begin
          blocked   <= blocked_now;
          scan_c    <= '0;
          have_free <= 1'b0;
          best_free <= '0;
          best_any  <= '0;
        end
        S_SCAN: begin
          // Strictly fewer uses wins, so ties keep the lower color.
          if (free_take) begin
            best_free <= scan_c;
            have_free <= 1'b1;
          end
          if (any_take) best_any <= scan_c;
          scan_c <= scan_c + ColorW'(1);
        end
        S_PICK: begin
          usage[pick]         <= usage[pick] + UseW'(1);
          result_valid        <= 1'b1;
          result.region_index <= region[IdW-1:0];
          result.color_index  <= pick;
          result.conflict     <= !have_free;
          result.last_region  <= (region + (RegW+1)'(1) == count_eff);
          region              <= region + (RegW+1)'(1);
        end
        default: ;
      endcase
    end
  end

  // Region colors are only read for regions already colored in this pass.
  always_ff @(posedge clk) begin
    if (state == S_PICK) colors[region[RegW-1:0]] <= pick;
  end
endmodule

// ===== rtl/core/rmgc_checker.sv =====
// Port-level checker for the region map greedy coloring core, with its bind.
// Depends on rmgc_pkg.
`timescale 1ns / 1ps
module rmgc_checker
  import rmgc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    result_valid,
  input result_t result
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after start");
  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_region |-> busy) else $error("result while idle");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("back to back results");
endmodule

bind region_map_greedy_coloring_core rmgc_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .result_valid(result_valid), .result(result)
);

// ===== sim/tb_region_map_greedy_coloring_core.sv =====
// Self-checking testbench for region_map_greedy_coloring_core: streams label maps,
// predicts the per-region colors in-house and compares every result transaction.
// Depends on rmgc_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_region_map_greedy_coloring_core;
  import rmgc_pkg::*;

  localparam int SIDE_LIM    = 256;
  localparam int REGION_LIM  = 32;
  localparam int COLOR_LIM   = 25;
  localparam int DRAIN_WAIT  = 3 * REGION_LIM + 20;  // final clear plus margin
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_CELLS = 210;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  cell_t            label = '0;
  logic             result_valid;
  result_t          result;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_GRID_SIDE;
  logic [CfgW-1:0]  cfg_data = '0;

  region_map_greedy_coloring_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .label(label),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Stimulus and expectation stores
  cell_t   cell_q[$];
  result_t color_q[$];
  int      errors = 0;
  bit      no_gaps = 1'b0;   // stretch of back-to-back transactions

  // Predictor state: our own copy of the block's map and coloring state
  logic [SideW-1:0]  side_reg = 9'd16;
  logic [CountW-1:0] count_reg = 6'd1;
  logic [5:0]        line_buf[SIDE_LIM];
  logic [5:0]        prev_cell;
  int unsigned       col_pos, row_pos;
  logic [31:0]       neighbors[REGION_LIM];
  logic [4:0]        region_color[REGION_LIM];
  int unsigned       usage[COLOR_LIM];

  task automatic report(input string what, input result_t got, input result_t want);
    errors++;
    $display("mismatch (%s): got r%0d c%0d x%0b l%0b, want r%0d c%0d x%0b l%0b", what,
             got.region_index, got.color_index, got.conflict, got.last_region,
             want.region_index, want.color_index, want.conflict, want.last_region);
  endtask

  function automatic void clear_map_state();
    for (int i = 0; i < REGION_LIM; i++) neighbors[i] = '0;
    for (int i = 0; i < COLOR_LIM; i++) usage[i] = 0;
    prev_cell = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic int least_used(input logic [COLOR_LIM-1:0] allowed);
    int best;
    best = -1;
    for (int c = 0; c < COLOR_LIM; c++)
      if (allowed[c] && (best < 0 || usage[c] < usage[best])) best = c;
    return best;
  endfunction

  // Advance the map by one cell; on the final cell, color every region
  function automatic void predict_colors(input cell_t c);
    int unsigned side, cnt, col;
    logic [5:0] here;
    logic [COLOR_LIM-1:0] blocked;
    int pick;
    bit clash;
    result_t r;
    side = side_reg < 2 ? 2 : (side_reg > SIDE_LIM ? SIDE_LIM : side_reg);
    cnt = count_reg > REGION_LIM ? REGION_LIM : count_reg;
    if (col_pos >= side) begin
      col_pos = 0;
      if (row_pos < 255) row_pos++;
    end
    col = col_pos;
    here = c.assigned ? {1'b1, c.region_id} : 6'd0;
    if (c.assigned) begin
      if (col > 0 && prev_cell[5] && prev_cell[4:0] != c.region_id) begin
        neighbors[c.region_id][prev_cell[4:0]] = 1'b1;
        neighbors[prev_cell[4:0]][c.region_id] = 1'b1;
      end
      if (row_pos > 0 && line_buf[col][5] && line_buf[col][4:0] != c.region_id) begin
        neighbors[c.region_id][line_buf[col][4:0]] = 1'b1;
        neighbors[line_buf[col][4:0]][c.region_id] = 1'b1;
      end
    end
    line_buf[col] = here;
    prev_cell = here;
    col_pos = col + 1;
    if (!c.last_cell) return;
    for (int k = 0; k < cnt; k++) begin
      blocked = '0;
      for (int j = 0; j < k; j++)
        if (neighbors[k][j]) blocked[region_color[j]] = 1'b1;
      clash = 1'b0;
      pick = least_used(~blocked);
      if (pick < 0) begin
        clash = 1'b1;
        pick = least_used('1);
      end
      region_color[k] = pick[4:0];
      usage[pick]++;
      r.region_index = k[4:0];
      r.color_index = pick[4:0];
      r.conflict = clash;
      r.last_region = (k + 1 == cnt);
      color_q = {color_q, r};
    end
    clear_map_state();
  endfunction

  // Driver: hold start until accepted, then pick the next cell or idle
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (cell_q.size() != 0) begin
        label <= cell_q.pop_front();
        start <= 1'b1;
        if (no_gaps) gap <= 0;
        else case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: gap <= 0;
          6, 7, 8:          gap <= $urandom_range(1, 3);
          default:          gap <= $urandom_range(5, 40);
        endcase
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted cell, check every result strobe
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) predict_colors(label);
      if (result_valid) begin
        if (color_q.size() == 0) report("unexpected", result, '0);
        else if (result !== color_q[0]) report("field", result, color_q.pop_front());
        else void'(color_q.pop_front());
      end
      if ((start && !busy) || result_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[region_map_greedy_coloring_core] ERROR");
        $finish;
      end
    end
  end

  // Wait until every cell is in and every result is out, then let the pass finish
  task automatic drain();
    while (cell_q.size() != 0 || start) @(posedge clk);
    while (color_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_config(input logic [CfgW-1:0] side, input logic [CfgW-1:0] cnt);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_GRID_SIDE;
    cfg_data <= side;
    side_reg = side;
    @(posedge clk);
    cfg_index <= CFG_REGION_COUNT;
    cfg_data <= cnt;
    count_reg = cnt[CountW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void push_cell(input int id, input bit asg, input bit fin);
    cell_t c;
    c.region_id = id[4:0];
    c.assigned = asg;
    c.last_cell = fin;
    cell_q = {cell_q, c};
  endfunction

  int sent;
  initial begin
    int side, cnt, ncells, lim;
    clear_map_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: unassigned cell, top label, early final cell
    push_cell(0, 1, 0); push_cell(31, 1, 0); push_cell(5, 0, 0); push_cell(0, 1, 1);
    drain();

    // Force a conflict: regions 0..24 take distinct colors, 25 touches them all
    set_config(2, 26);
    for (int k = 0; k < 25; k++) begin
      push_cell(25, 1, 0);
      push_cell(k, 1, k == 24);
    end
    drain();

    // Side below range, count above range
    set_config(0, 40);
    for (int k = 0; k < 8; k++) push_cell(k == 3 ? 31 : $urandom_range(0, 31), 1, k == 7);
    drain();

    // Side above range, count zero: final cell yields no results
    set_config(511, 0);
    push_cell(1, 1, 0); push_cell(2, 1, 0); push_cell(3, 1, 1);
    drain();

    // Narrow map past its last row, back to back
    no_gaps = 1'b1;
    set_config(1, 3);
    for (int k = 0; k < 40; k++) push_cell($urandom_range(0, 3), $urandom_range(0, 3) != 0, k == 39);
    drain();
    no_gaps = 1'b0;

    // Random maps: mostly small full maps, some short, long, odd configurations
    sent = 0;
    while (sent < RANDOM_CELLS) begin
      case ($urandom_range(0, 9))
        0:       side = $urandom_range(0, 1);
        1:       side = $urandom_range(257, 511);
        2:       side = 256;
        default: side = $urandom_range(2, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       cnt = $urandom_range(33, 511);
        1:       cnt = 0;
        default: cnt = $urandom_range(1, 32);
      endcase
      set_config(side, cnt);
      side = side < 2 ? 2 : (side > SIDE_LIM ? SIDE_LIM : side);
      lim = (cnt[5:0] > 29) ? 31 : cnt[5:0] + 2;
      if (side > 8) ncells = $urandom_range(1, 40);
      else case ($urandom_range(0, 5))
        0:       ncells = $urandom_range(1, side * side);
        1:       ncells = side * side + $urandom_range(1, 2 * side);
        default: ncells = side * side;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ncells; k++)
        push_cell($urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, lim),
                  $urandom_range(0, 6) != 0, k == ncells - 1);
      sent += ncells;
      drain();
    end

    if (color_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("[region_map_greedy_coloring_core] OK");
    end else begin
      $display("[region_map_greedy_coloring_core] ERROR");
    end
    $finish;
  end
endmodule
